// ----- design/bca_pkg.sv -----
`timescale 1ns / 1ps

package bca_pkg;

  // Field and map geometry
  localparam int CL_W          = 14;     // cluster number
  localparam int CNT_W         = 15;     // cluster count register
  localparam int BYTE_W        = 11;     // byte index inside the used part of the map
  localparam int USED_W        = 12;     // used byte count, up to 2048
  localparam int CLUSTER_LIMIT = 16384;
  localparam int MAP_BYTES_DEF = 2048;

  typedef enum logic [1:0] {
    CMD_FORMAT  = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_NO_SPACE = 2'd1,
    STAT_RANGE    = 2'd2
  } stat_t;

  typedef enum logic [3:0] {
    S_RST_FILL,
    S_IDLE,
    S_FMT,
    S_ALC_TEST,
    S_ALC_RESCAN,
    S_ALC_PICK,
    S_ALC_CLR,
    S_ALC_SCAN,
    S_REL_TEST,
    S_REL_SET,
    S_RESP
  } ctl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic  in_load;
    logic  fill_init;
    logic  fill_step;
    logic  fmt_ptr;
    logic  scan_start;
    logic  scan_from_zero;
    logic  scan_step;
    logic  rd_issue;
    logic  rd_sel_cin;
    logic  take_alloc;
    logic  rmw_wr;
    logic  rmw_set;
    logic  rel_refill;
    logic  out_load;
    logic  out_alloc;
    stat_t out_status;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic nf_zero;
    logic nf_stale;
    logic fill_last;
    logic scan_done;
    logic cin_bad;
  } dp_sts_t;

  // Free bits of byte b that belong to clusters 1 .. eff-1
  function automatic logic [7:0] valid_mask(logic [13:0] b, logic [CNT_W-1:0] eff);
    logic [13:0] full;
    logic [2:0]  r;
    logic [7:0]  m;
    full = {2'b00, eff[CNT_W-1:3]};
    r    = eff[2:0];
    if (b < full) begin
      m = 8'hff;
    end else if (b == full) begin
      m = ~(8'hff >> r);
    end else begin
      m = 8'h00;
    end
    if (b == 14'd0) begin
      m = m & 8'h7f;
    end
    return m;
  endfunction

  // Position of the highest set bit, counted from bit 7
  function automatic logic [2:0] first_free(logic [7:0] v);
    logic [2:0] p;
    p = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (v[7 - k]) begin
        p = 3'(k);
      end
    end
    return p;
  endfunction

endpackage

// ----- design/bca_ctrl.sv -----
`timescale 1ns / 1ps

module bca_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  output logic               out_valid,
  input  logic               out_ready,
  output bca_pkg::dp_cmd_t   cmd,
  input  bca_pkg::dp_sts_t   sts
);

  bca_pkg::ctl_state_t state_r, state_nxt;
  bca_pkg::stat_t      res_st_r, res_st_nxt;
  logic                res_alloc_r, res_alloc_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == bca_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bca_pkg::S_RST_FILL: begin
        if (sts.fill_last) state_nxt = bca_pkg::S_IDLE;
      end
      bca_pkg::S_IDLE: begin
        if (in_valid) begin
          case (in_command)
            bca_pkg::CMD_FORMAT:  state_nxt = bca_pkg::S_FMT;
            bca_pkg::CMD_ALLOC:   state_nxt = bca_pkg::S_ALC_TEST;
            bca_pkg::CMD_RELEASE: state_nxt = bca_pkg::S_REL_TEST;
            default:              state_nxt = bca_pkg::S_RESP;
          endcase
        end
      end
      bca_pkg::S_FMT: begin
        if (sts.fill_last) state_nxt = bca_pkg::S_RESP;
      end
      bca_pkg::S_ALC_TEST: begin
        if (!sts.nf_zero && sts.nf_stale) state_nxt = bca_pkg::S_ALC_RESCAN;
        else                              state_nxt = bca_pkg::S_ALC_PICK;
      end
      bca_pkg::S_ALC_RESCAN: begin
        if (sts.scan_done) state_nxt = bca_pkg::S_ALC_PICK;
      end
      bca_pkg::S_ALC_PICK: begin
        if (sts.nf_zero) state_nxt = bca_pkg::S_RESP;
        else             state_nxt = bca_pkg::S_ALC_CLR;
      end
      bca_pkg::S_ALC_CLR:  state_nxt = bca_pkg::S_ALC_SCAN;
      bca_pkg::S_ALC_SCAN: begin
        if (sts.scan_done) state_nxt = bca_pkg::S_RESP;
      end
      bca_pkg::S_REL_TEST: begin
        if (sts.cin_bad) state_nxt = bca_pkg::S_RESP;
        else             state_nxt = bca_pkg::S_REL_SET;
      end
      bca_pkg::S_REL_SET: state_nxt = bca_pkg::S_RESP;
      bca_pkg::S_RESP: begin
        if (slot_free) state_nxt = bca_pkg::S_IDLE;
      end
      default: state_nxt = bca_pkg::S_IDLE;
    endcase
  end

  // Datapath commands and pending result
  always_comb begin
    cmd            = '0;
    cmd.out_status = res_st_r;
    cmd.out_alloc  = res_alloc_r;
    res_st_nxt     = res_st_r;
    res_alloc_nxt  = res_alloc_r;
    case (state_r)
      bca_pkg::S_RST_FILL: begin
        cmd.fill_step = 1'b1;
      end
      bca_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.in_load   = 1'b1;
          res_st_nxt    = bca_pkg::STAT_DONE;
          res_alloc_nxt = 1'b0;
          if (in_command == bca_pkg::CMD_FORMAT) cmd.fill_init = 1'b1;
        end
      end
      bca_pkg::S_FMT: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_last) cmd.fmt_ptr = 1'b1;
      end
      bca_pkg::S_ALC_TEST: begin
        if (!sts.nf_zero && sts.nf_stale) begin
          cmd.scan_start     = 1'b1;
          cmd.scan_from_zero = 1'b1;
        end
      end
      bca_pkg::S_ALC_RESCAN: begin
        cmd.scan_step = 1'b1;
      end
      bca_pkg::S_ALC_PICK: begin
        if (sts.nf_zero) begin
          res_st_nxt = bca_pkg::STAT_NO_SPACE;
        end else begin
          cmd.rd_issue   = 1'b1;
          cmd.take_alloc = 1'b1;
        end
      end
      bca_pkg::S_ALC_CLR: begin
        cmd.rmw_wr     = 1'b1;
        cmd.scan_start = 1'b1;
      end
      bca_pkg::S_ALC_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) res_alloc_nxt = 1'b1;
      end
      bca_pkg::S_REL_TEST: begin
        if (sts.cin_bad) begin
          res_st_nxt = bca_pkg::STAT_RANGE;
        end else begin
          cmd.rd_issue   = 1'b1;
          cmd.rd_sel_cin = 1'b1;
        end
      end
      bca_pkg::S_REL_SET: begin
        cmd.rmw_wr     = 1'b1;
        cmd.rmw_set    = 1'b1;
        cmd.rel_refill = 1'b1;
      end
      bca_pkg::S_RESP: begin
        cmd.out_load = slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Result valid: set on load, drop on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)                    out_valid_nxt = 1'b1;
    else if (out_valid_r && out_ready)   out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bca_pkg::S_RST_FILL;
      out_valid_r <= 1'b0;
      res_st_r    <= bca_pkg::STAT_DONE;
      res_alloc_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      res_st_r    <= res_st_nxt;
      res_alloc_r <= res_alloc_nxt;
    end
  end

endmodule

// ----- design/bca_dp.sv -----
`timescale 1ns / 1ps

module bca_dp #(
  parameter int MAP_BYTES = bca_pkg::MAP_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [bca_pkg::CNT_W-1:0]   cluster_count,
  input  logic [bca_pkg::CL_W-1:0]    in_cluster_in,
  input  bca_pkg::dp_cmd_t            cmd,
  output bca_pkg::dp_sts_t            sts,
  output logic [bca_pkg::CL_W-1:0]    out_cluster_out,
  output logic [1:0]                  out_status
);

  localparam int AW  = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int CAP = (MAP_BYTES * 8 < bca_pkg::CLUSTER_LIMIT) ? MAP_BYTES * 8
                                                                 : bca_pkg::CLUSTER_LIMIT;
  localparam int BW  = bca_pkg::BYTE_W;
  localparam int UW  = bca_pkg::USED_W;
  localparam int CW  = bca_pkg::CL_W;
  localparam int NW  = bca_pkg::CNT_W;

  logic [7:0]    mem [MAP_BYTES];
  logic [7:0]    rdata_r;

  logic [CW-1:0] next_free_r, next_free_nxt;
  logic [CW-1:0] cin_r;
  logic [CW-1:0] alloc_r;
  logic [AW-1:0] fill_addr_r;
  logic [NW-1:0] fill_eff_r;
  logic [BW-1:0] cur_r;
  logic [UW-1:0] issued_r;
  logic          chk_v_r;
  logic [BW-1:0] chk_addr_r;
  logic [BW-1:0] rmw_byte_r;
  logic [7:0]    rmw_bit_r;
  logic [CW-1:0] out_cluster_r;
  bca_pkg::stat_t out_status_r;

  logic [NW-1:0] eff;
  logic [UW-1:0] used;
  logic [NW-1:0] used_sum;
  logic [BW-1:0] start_byte;
  logic [BW-1:0] rd_byte;
  logic [UW-1:0] cur_inc;
  logic [7:0]    hit_bits;
  logic          hit;
  logic          scan_done;
  logic          issue;
  logic [CW-1:0] found;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;
  logic          mem_re;
  logic [AW-1:0] mem_ra;

  // Effective count and used byte span
  assign eff      = (cluster_count < NW'(CAP)) ? cluster_count : NW'(CAP);
  assign used_sum = eff + NW'(7);
  assign used     = UW'(used_sum >> 3);

  // Check stage of the scan
  assign hit_bits  = rdata_r & bca_pkg::valid_mask({3'b000, chk_addr_r}, eff);
  assign hit       = chk_v_r && (hit_bits != 8'h00);
  assign found     = {chk_addr_r, bca_pkg::first_free(hit_bits)};
  assign scan_done = hit || (!chk_v_r && (issued_r == used));
  assign issue     = cmd.scan_step && !scan_done && (issued_r != used);
  assign cur_inc   = {1'b0, cur_r} + UW'(1);

  assign start_byte = cmd.scan_from_zero ? '0 : next_free_r[CW-1:3];
  assign rd_byte    = cmd.rd_sel_cin ? cin_r[CW-1:3] : next_free_r[CW-1:3];

  assign sts.nf_zero   = (next_free_r == '0);
  assign sts.nf_stale  = ({1'b0, next_free_r} >= eff);
  assign sts.fill_last = (fill_addr_r == AW'(MAP_BYTES - 1));
  assign sts.scan_done = scan_done;
  assign sts.cin_bad   = (cin_r == '0) || ({1'b0, cin_r} >= eff);

  // Memory port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = AW'(rmw_byte_r);
    mem_wd = cmd.rmw_set ? (rdata_r | rmw_bit_r) : (rdata_r & ~rmw_bit_r);
    if (cmd.fill_step) begin
      mem_we = 1'b1;
      mem_wa = fill_addr_r;
      mem_wd = bca_pkg::valid_mask(14'(fill_addr_r), fill_eff_r);
    end else if (cmd.rmw_wr) begin
      mem_we = 1'b1;
    end
    mem_re = issue || cmd.rd_issue;
    mem_ra = issue ? AW'(cur_r) : AW'(rd_byte);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata_r <= mem[mem_ra];
  end

  // Pointer update
  always_comb begin
    next_free_nxt = next_free_r;
    if (cmd.fmt_ptr) begin
      next_free_nxt = (fill_eff_r >= NW'(2)) ? CW'(1) : '0;
    end else if (cmd.scan_step && scan_done) begin
      next_free_nxt = hit ? found : '0;
    end else if (cmd.rel_refill && (next_free_r == '0)) begin
      next_free_nxt = cin_r;
    end
  end

  // Control registers of the map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_free_r <= CW'(1);
      fill_addr_r <= '0;
      fill_eff_r  <= NW'(CAP);
      chk_v_r     <= 1'b0;
      issued_r    <= '0;
      cur_r       <= '0;
    end else begin
      next_free_r <= next_free_nxt;
      if (cmd.fill_init) begin
        fill_addr_r <= '0;
        fill_eff_r  <= eff;
      end else if (cmd.fill_step) begin
        fill_addr_r <= fill_addr_r + AW'(1);
      end
      if (cmd.scan_start) begin
        cur_r    <= ({1'b0, start_byte} >= used) ? '0 : start_byte;
        issued_r <= '0;
        chk_v_r  <= 1'b0;
      end else if (cmd.scan_step) begin
        chk_v_r <= issue;
        if (issue) begin
          cur_r    <= (cur_inc == used) ? '0 : BW'(cur_inc);
          issued_r <= issued_r + UW'(1);
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (issue) chk_addr_r <= cur_r;
    if (cmd.in_load) cin_r <= in_cluster_in;
    if (cmd.take_alloc) alloc_r <= next_free_r;
    if (cmd.rd_issue) begin
      rmw_byte_r <= rd_byte;
      rmw_bit_r  <= 8'h80 >> (cmd.rd_sel_cin ? cin_r[2:0] : next_free_r[2:0]);
    end
    if (cmd.out_load) begin
      out_cluster_r <= cmd.out_alloc ? alloc_r : '0;
      out_status_r  <= cmd.out_status;
    end
  end

  assign out_cluster_out = out_cluster_r;
  assign out_status      = out_status_r;

`ifndef SYNTH
  a_chk_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    chk_v_r |-> ({1'b0, chk_addr_r} < used))
    else $error("scan checks a byte outside the used map");

  a_found_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_step && hit) |=> (next_free_r != '0))
    else $error("scan hit left an empty pointer");

  a_rmw_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rmw_wr |-> $past(cmd.rd_issue))
    else $error("map byte written back without a preceding read");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> (issued_r <= used))
    else $error("scan issued more reads than used bytes");
`endif

endmodule

// ----- design/bitmap_cluster_allocator.sv -----
`timescale 1ns / 1ps
// Allocate scans the map onward from the pointer, after a first scan from byte zero
//   when the pointer is stale.
// Throughput: one item at a time; the map memory's single read port sets the scan
//   at one byte per cycle, so the worst case walks the whole used map.
// Reset: synchronous active low; a fill pass then formats the map for the full
//   cluster count while no item is taken (configuration writes are).

module bitmap_cluster_allocator #(
  parameter int MAP_BYTES = bca_pkg::MAP_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_command,
  input  logic [bca_pkg::CL_W-1:0]      in_cluster_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bca_pkg::CL_W-1:0]      out_cluster_out,
  output logic [1:0]                    out_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bca_pkg::CNT_W-1:0]     cfg_data
);

  logic [bca_pkg::CNT_W-1:0] cluster_count_r;
  bca_pkg::dp_cmd_t          cmd;
  bca_pkg::dp_sts_t          sts;

  // Cluster count register: take every transfer
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cluster_count_r <= bca_pkg::CNT_W'(bca_pkg::CLUSTER_LIMIT);
    end else if (cfg_valid) begin
      cluster_count_r <= cfg_data;
    end
  end

  bca_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  bca_dp #(
    .MAP_BYTES (MAP_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cluster_count   (cluster_count_r),
    .in_cluster_in   (in_cluster_in),
    .cmd             (cmd),
    .sts             (sts),
    .out_cluster_out (out_cluster_out),
    .out_status      (out_status)
  );

endmodule
